@@ rtl/qsl_pkg.sv @@
// shared constants, types and sequencer states of the quicksort sorter
package qsl_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int VALUE_WIDTH  = 32;
  localparam int STACK_DEPTH  = MAX_ELEMENTS;

  localparam int IDX_W   = $clog2(MAX_ELEMENTS);
  localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int ST_AW   = $clog2(STACK_DEPTH);
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W = 2 * IDX_W;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [SP_W-1:0]               sp_t;
  typedef logic [ENTRY_W-1:0]            entry_t;

  // one result beat from the sort engine toward the output register
  typedef struct packed {
    logic   valid;
    value_t value;
    logic   last;
    logic   overflow;
  } qsl_res_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_POP,
    S_POP_WAIT,
    S_PIVOT,
    S_CMP,
    S_SWAP_RD,
    S_SWAP_WR,
    S_FIN_RD,
    S_FIN_WR,
    S_PUSH_A,
    S_PUSH_B,
    S_EMIT_RD,
    S_EMIT
  } qsl_state_t;

endpackage

@@ rtl/qsl_ram.sv @@
// simple dual-port ram with registered read data
module qsl_ram #(
  parameter  int DEPTH = 64,
  parameter  int WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/qsl_engine.sv @@
// load, lomuto partition sequencer with range stack, and ordered read-out
module qsl_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  qsl_pkg::value_t   value,
  input  logic              last_item,
  output logic              ready,
  output qsl_pkg::qsl_res_t res,
  input  logic              res_take
);
  import qsl_pkg::*;

  qsl_state_t state, state_next;

  cnt_t   count, count_next;
  logic   ovf, ovf_next;
  sp_t    sp, sp_next;
  idx_t   lo, lo_next, hi, hi_next;
  idx_t   j, j_next, slot, slot_next, k, k_next;
  value_t pivot, pivot_next, aj, aj_next;

  // element store port signals
  logic                   el_we, el_re;
  idx_t                   el_waddr, el_raddr;
  logic [VALUE_WIDTH-1:0] el_wdata, el_rdata;
  // range stack port signals
  logic                   st_we, st_re;
  logic [ST_AW-1:0]       st_waddr, st_raddr;
  entry_t                 st_wdata, st_rdata;

  qsl_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(VALUE_WIDTH)) u_elem (
    .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
    .re(el_re), .raddr(el_raddr), .rdata(el_rdata)
  );

  qsl_ram #(.DEPTH(STACK_DEPTH), .WIDTH(ENTRY_W)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  // shared decisions
  logic   in_fire, le, j_end, e_ok, push_a, push_b, emit_last, stack_room;
  idx_t   e_lo, e_hi;
  value_t rd_val;

  assign in_fire    = in_valid && ready;
  assign rd_val     = $signed(el_rdata);
  assign le         = rd_val <= pivot;
  assign j_end      = (CNT_W'(j) + 1'b1) == CNT_W'(hi);
  assign e_lo       = st_rdata[ENTRY_W-1:IDX_W];
  assign e_hi       = st_rdata[IDX_W-1:0];
  assign e_ok       = (e_lo < e_hi) && (CNT_W'(e_hi) < count);
  assign stack_room = sp < SP_W'(STACK_DEPTH);
  assign push_a     = (CNT_W'(slot) + 1'b1) < CNT_W'(hi);
  assign push_b     = CNT_W'(slot) > (CNT_W'(lo) + 1'b1);
  assign emit_last  = (CNT_W'(k) + 1'b1) == count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:     if (in_fire && last_item) state_next = S_START;
      S_START:    state_next = (count < CNT_W'(2)) ? S_EMIT_RD : S_POP;
      S_POP:      state_next = (sp == '0) ? S_EMIT_RD : S_POP_WAIT;
      S_POP_WAIT: state_next = e_ok ? S_PIVOT : S_POP;
      S_PIVOT:    state_next = S_CMP;
      S_CMP: begin
        if (le && slot != j) state_next = S_SWAP_RD;
        else if (j_end)      state_next = S_FIN_RD;
        else                 state_next = S_CMP;
      end
      S_SWAP_RD:  state_next = S_SWAP_WR;
      S_SWAP_WR:  state_next = j_end ? S_FIN_RD : S_CMP;
      S_FIN_RD:   state_next = (slot != hi) ? S_FIN_WR : S_PUSH_A;
      S_FIN_WR:   state_next = S_PUSH_A;
      S_PUSH_A:   state_next = S_PUSH_B;
      S_PUSH_B:   state_next = S_POP;
      S_EMIT_RD:  state_next = S_EMIT;
      S_EMIT:     if (res_take && emit_last) state_next = S_LOAD;
      default:    state_next = S_LOAD;
    endcase
  end

  // outputs, memory ports and datapath
  always_comb begin
    idx_t slot_adv;
    slot_adv   = le ? slot + 1'b1 : slot;
    ready      = 1'b0;
    res        = '0;
    el_we      = 1'b0;
    el_waddr   = '0;
    el_wdata   = '0;
    el_re      = 1'b0;
    el_raddr   = '0;
    st_we      = 1'b0;
    st_waddr   = '0;
    st_wdata   = '0;
    st_re      = 1'b0;
    st_raddr   = '0;
    count_next = count;
    ovf_next   = ovf;
    sp_next    = sp;
    lo_next    = lo;
    hi_next    = hi;
    j_next     = j;
    slot_next  = slot;
    k_next     = k;
    pivot_next = pivot;
    aj_next    = aj;
    case (state)
      S_LOAD: begin
        ready = 1'b1;
        if (in_fire) begin
          if (count < CNT_W'(MAX_ELEMENTS)) begin
            el_we      = 1'b1;
            el_waddr   = count[IDX_W-1:0];
            el_wdata   = value;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end
      end
      S_START: begin
        sp_next = '0;
        if (count >= CNT_W'(2)) begin
          st_we    = 1'b1;
          st_waddr = '0;
          st_wdata = {idx_t'(0), IDX_W'(count - 1'b1)};
          sp_next  = SP_W'(1);
        end
      end
      S_POP: begin
        if (sp != '0) begin
          sp_next  = sp - 1'b1;
          st_re    = 1'b1;
          st_raddr = ST_AW'(sp - 1'b1);
        end
      end
      S_POP_WAIT: begin
        lo_next = e_lo;
        hi_next = e_hi;
        if (e_ok) begin
          el_re    = 1'b1;
          el_raddr = e_hi;
        end
      end
      S_PIVOT: begin
        pivot_next = rd_val;
        slot_next  = lo;
        j_next     = lo;
        el_re      = 1'b1;
        el_raddr   = lo;
      end
      S_CMP: begin
        if (le && slot != j) begin
          aj_next  = rd_val;
          el_re    = 1'b1;
          el_raddr = slot;
        end else begin
          slot_next = slot_adv;
          j_next    = j + 1'b1;
          el_re     = 1'b1;
          el_raddr  = j_end ? slot_adv : j + 1'b1;
        end
      end
      S_SWAP_RD: begin
        el_we    = 1'b1;
        el_waddr = j;
        el_wdata = el_rdata;
      end
      S_SWAP_WR: begin
        el_we     = 1'b1;
        el_waddr  = slot;
        el_wdata  = aj;
        slot_next = slot + 1'b1;
        j_next    = j + 1'b1;
        el_re     = 1'b1;
        el_raddr  = j_end ? slot + 1'b1 : j + 1'b1;
      end
      S_FIN_RD: begin
        if (slot != hi) begin
          el_we    = 1'b1;
          el_waddr = hi;
          el_wdata = el_rdata;
        end
      end
      S_FIN_WR: begin
        el_we    = 1'b1;
        el_waddr = slot;
        el_wdata = pivot;
      end
      S_PUSH_A: begin
        if (push_a && stack_room) begin
          st_we    = 1'b1;
          st_waddr = ST_AW'(sp);
          st_wdata = {slot + 1'b1, hi};
          sp_next  = sp + 1'b1;
        end
      end
      S_PUSH_B: begin
        if (push_b && stack_room) begin
          st_we    = 1'b1;
          st_waddr = ST_AW'(sp);
          st_wdata = {lo, slot - 1'b1};
          sp_next  = sp + 1'b1;
        end
      end
      S_EMIT_RD: begin
        k_next   = '0;
        el_re    = 1'b1;
        el_raddr = '0;
      end
      S_EMIT: begin
        res.valid    = 1'b1;
        res.value    = rd_val;
        res.last     = emit_last;
        res.overflow = ovf;
        if (res_take) begin
          if (emit_last) begin
            count_next = '0;
            ovf_next   = 1'b0;
            sp_next    = '0;
          end else begin
            k_next   = k + 1'b1;
            el_re    = 1'b1;
            el_raddr = k + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      sp    <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      sp    <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    j     <= j_next;
    slot  <= slot_next;
    k     <= k_next;
    pivot <= pivot_next;
    aj    <= aj_next;
  end

endmodule

@@ rtl/quicksort_lomuto_sorter_unit.sv @@
// top level of the quicksort sorter: sort engine and output register
//
// input channel: in_valid / in_stall carry one value per beat; the beat with
//   last_item high closes the set and starts the sort. up to 64 values are
//   kept, further beats of the set are dropped and flagged by overflow.
// output channel: out_valid / out_stall carry the set back in ascending
//   order, one value per beat, last_result high on the final one; overflow
//   is the same on every beat of a run.
// flow: while loading, in_stall is low and a value is taken on every valid
//   beat. the sort runs on one element ram and one comparator: a partition
//   step compares in S_CMP, a swap adds S_SWAP_RD and S_SWAP_WR, and each
//   range taken off the stack adds S_POP, S_POP_WAIT, S_PIVOT, S_FIN_RD, the
//   S_FIN_WR write when the pivot moves, S_PUSH_A and S_PUSH_B. read-out is
//   one beat per cycle while out_stall is low. in_stall stays high from the
//   closing beat until the final result has left the engine.
// reset: synchronous, clears the count, stack pointer, overflow flag and
//   out_valid of the output register; ram contents are not cleared.
// a stalled receiver holds the output register, and the engine waits with
//   the next value in its ram read register until the register frees up.
module quicksort_lomuto_sorter_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  qsl_pkg::value_t value,
  input  logic            last_item,
  output logic            out_valid,
  input  logic            out_stall,
  output qsl_pkg::value_t sorted_value,
  output logic            last_result,
  output logic            overflow
);
  import qsl_pkg::*;

  logic     ready;
  qsl_res_t res;
  logic     res_take;

  qsl_engine u_engine (
    .clk(clk), .rst(rst), .in_valid(in_valid), .value(value),
    .last_item(last_item), .ready(ready), .res(res), .res_take(res_take)
  );

  assign in_stall = !ready;

  // the register takes a new beat when empty or draining this cycle
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res_take) begin
      sorted_value <= res.value;
      last_result  <= res.last;
      overflow     <= res.overflow;
    end
  end

endmodule

@@ rtl/qsl_checker.sv @@
// port-level checks for the quicksort sorter, bound to the top level
module qsl_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            last_item,
  input logic            out_valid,
  input logic            out_stall,
  input qsl_pkg::value_t sorted_value,
  input logic            last_result,
  input logic            overflow
);

  // after reset the block is loading and shows no result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("sorter not idle after reset");

  // the closing beat of a set starts the sort, so input is held off
  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_item |=> in_stall)
    else $error("input taken right after closing beat");

  // when out_valid rises on a beat that is not the final one, no new set is accepted
  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !last_result |-> in_stall)
    else $error("input open in the middle of a run");

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sorted_value)
      && $stable(last_result) && $stable(overflow))
    else $error("stalled result changed");

endmodule

bind quicksort_lomuto_sorter_unit qsl_checker u_qsl_checker (.*);
